### design/sort_then_binary_search_defines.svh
// Assertion macros for the sorted-store search block.
// Define NO_ASSERTIONS to compile every check away.
`ifndef SORT_THEN_BINARY_SEARCH_DEFINES_SVH
`define SORT_THEN_BINARY_SEARCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define STBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stbs: same-cycle check failed");
`define STBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stbs: next-cycle check failed");
`else
`define STBS_ASSERT_IMP(lbl, ante, cons)
`define STBS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### design/stbs_pkg.sv
package stbs_pkg;

  localparam int OPERAND_W = 32;
  localparam int POS_W     = 7;
  localparam int FUNC_W    = 2;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]           func;
    logic signed [OPERAND_W-1:0] operand;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } res_t;

endpackage

### design/sort_then_binary_search.sv
// Append and clear requests complete without leaving the idle state. A search holds the
// block while it probes the store through its single read port, at most clog2(count) + 1
// probes. The first search after an append, with more than one element stored, first runs
// an insertion sort on the same read port: each element in turn is compared with those
// before it, larger ones move up one place, and the element is written into the gap.
// Synchronous reset empties the store logically; the store contents are not cleared.
`include "sort_then_binary_search_defines.svh"

module sort_then_binary_search #(
  parameter int DEPTH = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  stbs_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_stall,
  output stbs_pkg::res_t  res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = stbs_pkg::POS_W;
  localparam int DW = stbs_pkg::OPERAND_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD_I = 9'b000000010,
    S_WT_I = 9'b000000100,
    S_RD_J = 9'b000001000,
    S_CMP  = 9'b000010000,
    S_PUT  = 9'b000100000,
    S_CHK  = 9'b001000000,
    S_SCMP = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic          sorted;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] low;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  logic signed [DW-1:0] item;
  logic signed [DW-1:0] key;
  logic          found_r;
  logic [PW-1:0] pos_r;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic signed [DW-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic signed [DW-1:0] rdata;

  logic                 accept;
  logic [CW-1:0]        j_dec;
  logic [CW-1:0]        i_inc;
  logic [CW-1:0]        mid_calc;
  logic [PW+CW-1:0]     mid_ext;
  logic signed [DW-1:0] cmp_b;
  logic                 cmp_gt;
  logic                 cmp_eq;
  logic                 res_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;

  assign j_dec    = j - CW'(1);
  assign i_inc    = i + CW'(1);
  // Same probe as low + (high - low) / 2 with high = hi - 1; hi > low here.
  assign mid_calc = low + ((hi - low - CW'(1)) >> 1);
  assign mid_ext  = {{PW{1'b0}}, mid};

  // The one comparator serves both the sort and the search.
  assign cmp_b  = (state == S_SCMP) ? key : item;
  assign cmp_gt = (rdata > cmp_b);
  assign cmp_eq = (rdata == cmp_b);

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = req.operand;
    raddr = i[AW-1:0];
    unique case (state)
      S_IDLE: begin
        we = accept && (req.func == stbs_pkg::FUNC_APPEND) && (count < CW'(DEPTH));
      end
      S_RD_J: begin
        raddr = j_dec[AW-1:0];
      end
      S_CMP: begin
        we    = cmp_gt;
        waddr = j[AW-1:0];
        wdata = rdata;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
        wdata = item;
      end
      S_CHK: begin
        raddr = mid_calc[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  stbs_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sorted    <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      if (state == S_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.func)
              stbs_pkg::FUNC_CLEAR: begin
                count  <= '0;
                sorted <= 1'b1;
              end
              stbs_pkg::FUNC_APPEND: begin
                if (count < CW'(DEPTH)) begin
                  count  <= count + CW'(1);
                  sorted <= 1'b0;
                end
              end
              stbs_pkg::FUNC_SEARCH: begin
                key <= req.operand;
                low <= '0;
                hi  <= count;
                if (!sorted && count > CW'(1)) begin
                  i     <= CW'(1);
                  state <= S_RD_I;
                end else begin
                  sorted <= 1'b1;
                  state  <= S_CHK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD_I: begin
          state <= S_WT_I;
        end
        S_WT_I: begin
          item  <= rdata;
          j     <= i;
          state <= S_RD_J;
        end
        S_RD_J: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (cmp_gt) begin
            j     <= j_dec;
            state <= (j_dec == '0) ? S_PUT : S_RD_J;
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (i_inc < count) begin
            i     <= i_inc;
            state <= S_RD_I;
          end else begin
            sorted <= 1'b1;
            state  <= S_CHK;
          end
        end
        S_CHK: begin
          if (low < hi) begin
            mid   <= mid_calc;
            state <= S_SCMP;
          end else begin
            found_r <= 1'b0;
            pos_r   <= '0;
            state   <= S_DONE;
          end
        end
        S_SCMP: begin
          priority if (cmp_eq) begin
            found_r <= 1'b1;
            pos_r   <= mid_ext[PW-1:0];
            state   <= S_DONE;
          end else if (cmp_gt) begin
            hi    <= mid;
            state <= S_CHK;
          end else begin
            low   <= mid + CW'(1);
            state <= S_CHK;
          end
        end
        S_DONE: begin
          if (res_free) begin
            res.found    <= found_r;
            res.position <= pos_r;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `STBS_ASSERT_IMP(a_stall_busy, state != S_IDLE, req_stall)
  `STBS_ASSERT_IMP(a_count_cap, 1'b1, count <= CW'(DEPTH))
  `STBS_ASSERT_IMP(a_sort_ptrs, state == S_RD_J || state == S_CMP || state == S_PUT,
                   j <= i && i < count && i != '0)
  `STBS_ASSERT_IMP(a_miss_zero, res_valid && !res.found, res.position == '0)
  `STBS_ASSERT_NXT(a_res_from_done, !res_valid && state != S_DONE, !res_valid)
  `STBS_ASSERT_IMP(a_search_bounds, state == S_CHK || state == S_SCMP,
                   low <= hi && hi <= count)

endmodule

### design/stbs_ram.sv
module stbs_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [AW-1:0]                          waddr,
  input  logic signed [stbs_pkg::OPERAND_W-1:0]  wdata,
  input  logic [AW-1:0]                          raddr,
  output logic signed [stbs_pkg::OPERAND_W-1:0]  rdata
);

  logic signed [stbs_pkg::OPERAND_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
